### sv/td_pkg.sv
// Package for the tracking differentiator: word constants, sequencer states, Q16.16 helpers.
`default_nettype none
package td_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;

    localparam logic signed [31:0] WMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WMIN = 32'sh8000_0000;

    localparam logic [30:0] SPEED_RESET  = 31'd6553600;
    localparam logic [16:0] PERIOD_RESET = 17'd131;
    localparam logic [16:0] FILTER_RESET = 17'd655;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SPEED  = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_X1, ST_D, ST_D0, ST_T, ST_Y, ST_CMP,
        ST_DD, ST_RY, ST_E8, ST_S, ST_SQRT, ST_DIFF, ST_HALF,
        ST_DIV, ST_A2, ST_F, ST_F2, ST_HV, ST_NV1, ST_HF, ST_NV2, ST_PUSH
    } state_t;

    // sign-magnitude to saturated word
    function automatic logic signed [31:0] sat_sm(input logic neg, input logic [63:0] mag);
        logic signed [31:0] res;
        if (!neg) begin
            res = (mag > 64'h7FFF_FFFF) ? WMAX : $signed(mag[31:0]);
        end else begin
            res = (mag > 64'h8000_0000) ? WMIN : $signed(32'd0 - mag[31:0]);
        end
        return res;
    endfunction

    function automatic logic [31:0] mag_of(input logic signed [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    function automatic logic signed [31:0] sneg(input logic signed [31:0] x);
        return sat_sm(!x[31] && (x != 32'sd0), {32'd0, mag_of(x)});
    endfunction

    function automatic logic signed [31:0] sabs(input logic signed [31:0] x);
        return sat_sm(1'b0, {32'd0, mag_of(x)});
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [32:0] s;
        logic signed [31:0] res;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) res = s[32] ? WMIN : WMAX;
        else res = s[31:0];
        return res;
    endfunction

    // product truncated toward zero, then saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [63:0] p;
        p = mag_of(a) * mag_of(b);
        return sat_sm(a[31] != b[31], {16'd0, p[63:FRACTION_BITS]});
    endfunction

endpackage
`default_nettype wire

### sv/tracking_differentiator.sv
// Top level of the tracking differentiator: config registers, sequencer and shared datapath.
//
// Second-order tracking differentiator built on the fhan time-optimal function.
// Input channel s_*: one Q16.16 target sample per transaction. Result channel
// m_*: the new tracked value (low word) and tracked rate (high word).
// The configuration port (APB style) holds speed_factor at 0x0, step_period at
// 0x4 and filter_factor at 0x8; write only while the block is idle.
// A sample's result takes longest when both divisions by h0 run and shortest
// when both fhan branches skip the divider. A single multiplier/adder is
// shared by every step, and the two divisions by h0 (one quotient bit a cycle)
// and the square root (one root bit a cycle) dominate. The next sample can be
// taken once the sequencer has pushed the result and returned to idle.
// s_tready is high only while the sequencer waits for a sample. The result goes
// into an output register; the next sample is taken while it waits, and the
// sequencer only holds at its end if the previous result is still untaken.
// Reset clears the tracked state and restores the register defaults.
`default_nettype none
module tracking_differentiator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // [31:0] target_sample
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [31:0] tracked_value, [63:32] tracked_rate
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import td_pkg::*;

    state_t state_reg, state_next;

    logic [30:0] speed_reg;
    logic [16:0] period_reg;
    logic [16:0] filter_reg;

    logic signed [31:0] v1_reg, v2_reg, tgt_reg, x1_reg, d_reg, d0_reg, y_reg;
    logic signed [31:0] t_reg, u_reg, a_reg, f_reg;
    logic [47:0] q_reg;
    logic [17:0] drem_reg;
    logic [26:0] srem_reg;
    logic [23:0] root_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, ret_reg;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    logic signed [31:0] r_w, h_w, h0_w, op_a, op_b, mul_res, add_res, div_res, half_w;
    logic [31:0] u_mag;
    logic [16:0] den_w;
    logic        wr_en, y_big, a_big, div_done, sq_done;
    logic [17:0] div_rs;
    logic        div_ge;
    logic [26:0] sq_rs, sq_trial;
    logic        sq_ge;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config-derived words; a zero filter step acts as one
    assign den_w = (filter_reg == 17'd0) ? 17'd1 : filter_reg;
    assign r_w   = $signed({1'b0, speed_reg});
    assign h_w   = $signed({15'd0, period_reg});
    assign h0_w  = $signed({15'd0, den_w});

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED:  prdata = {1'b0, speed_reg};
            REG_PERIOD: prdata = {15'd0, period_reg};
            REG_FILTER: prdata = {15'd0, filter_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // iteration steps of the divider and square root
    assign div_rs   = {drem_reg[16:0], q_reg[47]};
    assign div_ge   = div_rs >= {1'b0, den_w};
    assign div_done = (cnt_reg == 6'd47);
    assign div_res  = sat_sm(neg_reg, {16'd0, q_reg});
    assign sq_rs    = {srem_reg[24:0], q_reg[47:46]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_rs >= sq_trial;
    assign sq_done  = (cnt_reg == 6'd23);

    assign y_big  = mag_of(y_reg) > mag_of(d0_reg);
    assign a_big  = mag_of(a_reg) > mag_of(d_reg);
    assign u_mag  = mag_of(u_reg);
    assign half_w = sat_sm(u_reg[31], {33'd0, u_mag[31:1]});

    // operand selection for the shared multiplier and adder
    always_comb begin
        op_a = v1_reg;
        op_b = v2_reg;
        unique case (state_reg)
            ST_X1:   begin op_a = v1_reg; op_b = sneg(tgt_reg); end
            ST_D:    begin op_a = r_w;    op_b = h0_w;          end
            ST_D0:   begin op_a = d_reg;  op_b = h0_w;          end
            ST_T:    begin op_a = h0_w;   op_b = v2_reg;        end
            ST_Y:    begin op_a = x1_reg; op_b = t_reg;         end
            ST_DD:   begin op_a = d_reg;  op_b = d_reg;         end
            ST_RY:   begin op_a = r_w;    op_b = sabs(y_reg);   end
            ST_S:    begin op_a = t_reg;  op_b = u_reg;         end
            ST_DIFF: begin op_a = {8'd0, root_reg}; op_b = sneg(d_reg); end
            ST_HALF: begin
                op_a = v2_reg;
                op_b = (y_reg > 32'sd0) ? half_w : sneg(half_w);
            end
            ST_A2:   begin op_a = v2_reg; op_b = div_res;       end
            ST_HV:   begin op_a = h_w;    op_b = v2_reg;        end
            ST_NV1:  begin op_a = v1_reg; op_b = t_reg;         end
            ST_HF:   begin op_a = h_w;    op_b = f_reg;         end
            ST_NV2:  begin op_a = v2_reg; op_b = t_reg;         end
            default: begin op_a = v1_reg; op_b = v2_reg;        end
        endcase
    end

    assign mul_res = qmul(op_a, op_b);
    assign add_res = sadd(op_a, op_b);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_X1;
            ST_X1:   state_next = ST_D;
            ST_D:    state_next = ST_D0;
            ST_D0:   state_next = ST_T;
            ST_T:    state_next = ST_Y;
            ST_Y:    state_next = ST_CMP;
            ST_CMP:  state_next = y_big ? ST_DD : ST_DIV;
            ST_DD:   state_next = ST_RY;
            ST_RY:   state_next = ST_E8;
            ST_E8:   state_next = ST_S;
            ST_S:    state_next = ST_SQRT;
            ST_SQRT: if (sq_done) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_HALF;
            ST_HALF: state_next = ST_F;
            ST_DIV:  if (div_done) state_next = ret_reg ? ST_F2 : ST_A2;
            ST_A2:   state_next = ST_F;
            ST_F:    state_next = a_big ? ST_HV : ST_DIV;
            ST_F2:   state_next = ST_HV;
            ST_HV:   state_next = ST_NV1;
            ST_NV1:  state_next = ST_HF;
            ST_HF:   state_next = ST_NV2;
            ST_NV2:  state_next = ST_PUSH;
            ST_PUSH: if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            speed_reg     <= SPEED_RESET;
            period_reg    <= PERIOD_RESET;
            filter_reg    <= FILTER_RESET;
            v1_reg        <= 32'sd0;
            v2_reg        <= 32'sd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) begin
                unique case (paddr[3:2])
                    REG_SPEED:  speed_reg  <= pwdata[30:0];
                    REG_PERIOD: period_reg <= pwdata[16:0];
                    REG_FILTER: filter_reg <= pwdata[16:0];
                    default:    ;
                endcase
            end
            if (state_reg == ST_NV1) v1_reg <= add_res;
            if (state_reg == ST_NV2) v2_reg <= add_res;
            // output register: load at the end of a sample, clear on transaction
            if (state_reg == ST_PUSH && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: tgt_reg <= $signed(s_tdata);
            ST_X1:   x1_reg  <= add_res;
            ST_D:    d_reg   <= mul_res;
            ST_D0:   d0_reg  <= mul_res;
            ST_T:    t_reg   <= mul_res;
            ST_Y:    y_reg   <= add_res;
            ST_CMP: begin
                q_reg    <= {mag_of(y_reg), 16'd0};
                neg_reg  <= y_reg[31];
                drem_reg <= 18'd0;
                cnt_reg  <= 6'd0;
                ret_reg  <= 1'b0;
            end
            ST_DD:   t_reg <= mul_res;
            ST_RY:   u_reg <= mul_res;
            ST_E8:   u_reg <= sat_sm(1'b0, {29'd0, mag_of(u_reg), 3'b000});
            ST_S: begin
                q_reg    <= {add_res, 16'd0};
                srem_reg <= 27'd0;
                root_reg <= 24'd0;
                cnt_reg  <= 6'd0;
            end
            ST_SQRT: begin
                srem_reg <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
                root_reg <= {root_reg[22:0], sq_ge};
                q_reg    <= {q_reg[45:0], 2'b00};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            ST_DIFF: u_reg <= add_res;
            ST_HALF: a_reg <= add_res;
            ST_DIV: begin
                drem_reg <= div_ge ? (div_rs - {1'b0, den_w}) : div_rs;
                q_reg    <= {q_reg[46:0], div_ge};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            ST_A2:   a_reg <= add_res;
            ST_F: begin
                f_reg    <= (a_reg > 32'sd0) ? sneg(r_w) : r_w;
                q_reg    <= {mag_of(a_reg), 16'd0};
                neg_reg  <= a_reg[31];
                drem_reg <= 18'd0;
                cnt_reg  <= 6'd0;
                ret_reg  <= 1'b1;
            end
            ST_F2:   f_reg <= sneg(div_res);
            ST_HV:   t_reg <= mul_res;
            ST_HF:   t_reg <= mul_res;
            ST_PUSH: if (!out_valid_reg || m_tready) out_data_reg <= {v2_reg, v1_reg};
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_X1)
        else $error("accepted sample did not start the sequencer");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg <= 6'd47)
        else $error("divider ran past its last quotient bit");
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_PUSH))
        else $error("result appeared outside the push step");
    a_reset_defaults: assert property (@(posedge aclk)
        !aresetn |=> filter_reg == FILTER_RESET && speed_reg == SPEED_RESET)
        else $error("configuration defaults not restored by reset");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the tracking differentiator: predicts each tracked value/rate and checks the stream.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import td_pkg::*;

    localparam longint TRACKER_TIMEOUT = 4000000;
    localparam int SETTLE_CYCLES = 300;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] target_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] tracked_value, [63:32] tracked_rate
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tracking_differentiator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // predictor state and configuration, 64-bit signed working values
    longint trk_value;
    longint trk_rate;
    longint cfg_speed;
    longint cfg_period;
    longint cfg_filter;

    logic [63:0] expected_results[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycle_count;

    function automatic longint w_max();
        return 64'sd2147483647;
    endfunction

    function automatic longint w_min();
        return -64'sd2147483648;
    endfunction

    function automatic longint clamp_sm(input bit neg, input logic [127:0] mag);
        if (!neg) return (mag > 128'd2147483647) ? w_max() : longint'(mag[62:0]);
        if (mag > 128'd2147483648) return w_min();
        return -longint'(mag[62:0]);
    endfunction

    function automatic logic [63:0] mag64(input longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint q_neg(input longint x);
        return clamp_sm(x > 0, {64'd0, mag64(x)});
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > w_max()) return w_max();
        if (s < w_min()) return w_min();
        return s;
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] p;
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        return clamp_sm((a < 0) != (b < 0), p >> 16);
    endfunction

    function automatic longint q_div(input longint x, input longint den);
        logic [127:0] n;
        n = {64'd0, mag64(x)} << 16;
        return clamp_sm(x < 0, n / 128'(den));
    endfunction

    function automatic longint q_sqrt(input longint s);
        logic [127:0] target;
        logic [127:0] root;
        logic [127:0] cand;
        target = (s > 0) ? (128'(s) << 16) : 128'd0;
        root = 0;
        for (int b = 40; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= target) root = cand;
        end
        return clamp_sm(1'b0, root);
    endfunction

    // time-optimal synthesis function
    function automatic longint fhan_accel(input longint x1, input longint x2,
                                          input longint r, input longint h0);
        longint d, d0, y, a, a0, diff, half;
        d  = q_mul(r, h0);
        d0 = q_mul(d, h0);
        y  = q_add(x1, q_mul(h0, x2));
        if (mag64(y) > mag64(d0)) begin
            a0 = q_sqrt(q_add(q_mul(d, d),
                 clamp_sm(1'b0, {64'd0, mag64(q_mul(r, clamp_sm(1'b0, {64'd0, mag64(y)})))} * 8)));
            diff = q_add(a0, q_neg(d));
            half = clamp_sm(diff < 0, {64'd0, mag64(diff) >> 1});
            a = (y > 0) ? q_add(x2, half) : q_add(x2, q_neg(half));
        end else begin
            a = q_add(x2, q_div(y, h0));
        end
        if (mag64(a) > mag64(d)) return (a > 0) ? q_neg(r) : r;
        return q_neg(q_div(a, h0));
    endfunction

    function automatic logic [63:0] advance_tracker(input logic [31:0] sample);
        longint h0, f, nv1, nv2;
        h0  = (cfg_filter == 0) ? 1 : cfg_filter;
        f   = fhan_accel(q_add(trk_value, q_neg(longint'($signed(sample)))), trk_rate,
                         cfg_speed, h0);
        nv1 = q_add(trk_value, q_mul(cfg_period, trk_rate));
        nv2 = q_add(trk_rate, q_mul(cfg_period, f));
        trk_value = nv1;
        trk_rate  = nv2;
        return {nv2[31:0], nv1[31:0]};
    endfunction

    // result checker and receiver stall
    always @(posedge aclk) begin
        logic [63:0] want;
        int          errs;
        errs = 0;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                errs = errs + 1;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want[31:0]) begin
                    $error("tracked_value expected %h actual %h", want[31:0], m_tdata[31:0]);
                    errs = errs + 1;
                end
                if (m_tdata[63:32] !== want[63:32]) begin
                    $error("tracked_rate expected %h actual %h", want[63:32], m_tdata[63:32]);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) fail_count <= fail_count + errs;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (cycle_count > TRACKER_TIMEOUT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // tvalid stays high on return so back-to-back samples need no gap
    task automatic send_sample(input logic [31:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(advance_tracker(sample));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (index)
            REG_SPEED:  cfg_speed  = value[30:0];
            REG_PERIOD: cfg_period = value[16:0];
            default:    cfg_filter = value[16:0];
        endcase
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [31:0] r, input logic [31:0] h, input logic [31:0] h0);
        wait_drained();
        write_reg(REG_SPEED, r);
        write_reg(REG_PERIOD, h);
        write_reg(REG_FILTER, h0);
    endtask

    function automatic logic [31:0] random_target();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(65535) - 32768;
            2: return {{12{$urandom_range(1) == 1}}, 20'($urandom)};
            default: return 32'($signed($urandom_range(20)) - 10) <<< 16;
        endcase
    endfunction

    task automatic test_directed_extremes();
        logic [31:0] picks[10] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                   32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555,
                                   32'hAAAA_AAAA, 32'h0000_0001, 32'h7FFF_FFFF};
        foreach (picks[i]) send_sample(picks[i]);
        // zero filter factor acts as one; zero speed and period hold still
        set_config(32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 4; i++) send_sample(picks[i]);
        set_config(32'h7FFF_FFFF, 32'd65536, 32'd65536);
        for (int i = 0; i < 6; i++) send_sample(picks[i]);
        set_config(32'd1, 32'd1, 32'd1);
        for (int i = 0; i < 4; i++) send_sample(picks[i]);
    endtask

    task automatic test_random_tracking(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 120 == 119) begin
                case ($urandom_range(2))
                    0: set_config($urandom_range(32'h7FFF_FFFF, 1), $urandom_range(65536, 1),
                                  $urandom_range(65536, 1));
                    1: set_config($urandom_range(2000, 1) << 16, $urandom_range(700, 1),
                                  $urandom_range(7000, 1));
                    default: set_config(32'd6553600, 32'd131, 32'd655);
                endcase
            end
            send_sample(random_target());
        end
    endtask

    initial begin
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; cycle_count = 0; send_idle_pct = 37; recv_idle_pct = 84;
        trk_value = 0; trk_rate = 0;
        cfg_speed = 6553600; cfg_period = 131; cfg_filter = 655;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        set_config(32'd6553600, 32'd131, 32'd655);
        test_random_tracking(580);
        send_idle_pct = 84; recv_idle_pct = 37;
        test_random_tracking(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_tracking(580);
        wait_drained();
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
